// ===== sv/tgct_pkg.sv =====
// Package: shared types and constants of the tuple group count table.
`timescale 1ns / 1ps
`default_nettype none
package tgct_pkg;
	localparam int TableDepth = 256;
	localparam int IdxW = 8;
	localparam int CntW = 9;
	localparam int NumColumns = 64;
	localparam int MaxSelected = 8;

	typedef enum logic [1:0] {
		FUNC_CELL  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_COLS  = 2'd3
	} status_t;

	localparam logic [1:0] REG_SELECT = 2'd0;
	localparam logic [1:0] REG_NODE   = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	typedef enum logic [1:0] {
		OP_ROW   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// command word passed from front to back through the queue
	typedef struct packed {
		op_t         op;
		logic [63:0] tuple;
		status_t     fault;
		logic [7:0]  read_index;
	} cmd_t;
endpackage
`default_nettype wire

// ===== sv/tgct_front.sv =====
// Front end: ranks cells, builds the row tuple and issues row, read and clear commands.
`timescale 1ns / 1ps
`default_nettype none
module tgct_front
	import tgct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [5:0]  column,
	input  wire logic [7:0]  cell_value,
	input  wire logic        row_end,
	input  wire logic [7:0]  read_index,
	input  wire logic [63:0] select_mask,
	input  wire logic [5:0]  node_column,
	input  wire logic [8:0]  outcome_limit,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_full
);
	logic [63:0] tuple_q;
	status_t     fault_q;
	logic [63:0] sel;
	logic [63:0] below;
	logic [6:0]  rank;
	logic [6:0]  nsel;
	logic        hit;
	logic [63:0] tup_next;
	status_t     fault_next;
	logic        accept;

	assign in_stall = cmd_full;
	assign accept   = in_valid && !cmd_full;

	always_comb begin
		sel   = select_mask | (64'd1 << node_column);
		below = sel & ((64'd1 << column) - 64'd1);
		rank  = 7'($countones(below));
		nsel  = 7'($countones(sel));
		hit   = sel[column];
		tup_next   = tuple_q;
		fault_next = fault_q;
		if (hit) begin
			if ({1'b0, cell_value} >= outcome_limit)
				fault_next = ST_RANGE;
			if (rank < 7'(MaxSelected))
				tup_next[rank[2:0]*8 +: 8] = cell_value;
		end
		if (nsel > 7'(MaxSelected))
			fault_next = ST_COLS;
		else if (fault_next == ST_COLS)
			fault_next = ST_OK;
	end

	always_comb begin
		cmd_valid = 1'b0;
		cmd.op = OP_ROW;
		cmd.tuple = tup_next;
		cmd.fault = fault_next;
		cmd.read_index = read_index;
		if (in_valid) begin
			unique case (func_t'(func))
				FUNC_CELL:  cmd_valid = row_end;
				FUNC_READ:  begin cmd_valid = 1'b1; cmd.op = OP_READ; end
				FUNC_CLEAR: begin cmd_valid = 1'b1; cmd.op = OP_CLEAR; end
				default:    cmd_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_q <= '0;
			fault_q <= ST_OK;
		end else if (accept) begin
			if ((func == FUNC_CELL && row_end) || func == FUNC_CLEAR) begin
				tuple_q <= '0;
				fault_q <= ST_OK;
			end else if (func == FUNC_CELL) begin
				tuple_q <= tup_next;
				fault_q <= (fault_next == ST_RANGE) ? ST_RANGE : ST_OK;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/tgct_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module tgct_queue
	import tgct_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head,
	input  wire logic pop
);
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/tgct_back.sv =====
// Back end: sequential table search, weight update, entry append, read-out and table clear.
`timescale 1ns / 1ps
`default_nettype none
module tgct_back
	import tgct_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  wire cmd_t         cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        entry_index,
	output logic [31:0]       weight,
	output logic [63:0]       packed_tuple,
	output logic [8:0]        distinct_entries,
	output logic [1:0]        status
);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_RDW, S_WB, S_OUT} state_t;
	state_t         state_q;
	logic [63:0]    tup_mem [TableDepth];
	logic [31:0]    wt_mem  [TableDepth];
	logic [63:0]    tup_rd_q;
	logic [31:0]    wt_rd_q;
	logic [IdxW-1:0] addr_q;
	logic [CntW-1:0] total_q;
	logic [CntW-1:0] k_q;
	cmd_t           cur_q;
	logic           tup_we, wt_we;
	logic [63:0]    tup_wd;
	logic [31:0]    wt_wd;
	logic [IdxW-1:0] wa;

	always_ff @(posedge clk) begin
		if (tup_we) tup_mem[wa] <= tup_wd;
		if (wt_we) wt_mem[wa] <= wt_wd;
		tup_rd_q <= tup_mem[addr_q];
		wt_rd_q  <= wt_mem[addr_q];
	end

	always_comb begin
		tup_we = 1'b0; wt_we = 1'b0;
		tup_wd = cur_q.tuple; wt_wd = 32'd1; wa = addr_q;
		if (state_q == S_CMP && cur_q.op == OP_ROW && k_q == total_q
		    && total_q != CntW'(TableDepth)) begin
			tup_we = 1'b1; wt_we = 1'b1; wa = total_q[IdxW-1:0];
		end
		if (state_q == S_WB) begin
			wt_we = 1'b1;
			wt_wd = (wt_rd_q == '1) ? wt_rd_q : wt_rd_q + 32'd1;
		end
	end

	assign cmd_pop   = state_q == S_IDLE && cmd_valid;
	assign out_valid = state_q == S_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			k_q <= '0;
			addr_q <= '0;
			cur_q <= '0;
			entry_index <= '0;
			weight <= '0;
			packed_tuple <= '0;
			distinct_entries <= '0;
			status <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					cur_q <= cmd;
					k_q <= '0;
					unique case (cmd.op)
						OP_CLEAR: total_q <= '0;
						OP_READ: begin
							addr_q <= cmd.read_index;
							state_q <= S_RD;
						end
						default: begin
							addr_q <= '0;
							if (cmd.fault != ST_OK) begin
								entry_index <= '0; weight <= '0;
								packed_tuple <= cmd.tuple;
								distinct_entries <= total_q;
								status <= cmd.fault;
								state_q <= S_OUT;
							end else state_q <= S_RD;
						end
					endcase
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					distinct_entries <= total_q;
					if (cur_q.op == OP_READ) begin
						entry_index <= cur_q.read_index;
						if ({1'b0, cur_q.read_index} < total_q) begin
							weight <= wt_rd_q; packed_tuple <= tup_rd_q;
							status <= ST_OK;
						end else begin
							weight <= '0; packed_tuple <= '0; status <= ST_RANGE;
						end
						state_q <= S_OUT;
					end else if (k_q == total_q) begin
						packed_tuple <= cur_q.tuple;
						if (total_q == CntW'(TableDepth)) begin
							entry_index <= '0; weight <= '0; status <= ST_FULL;
						end else begin
							entry_index <= total_q[IdxW-1:0]; weight <= 32'd1;
							status <= ST_OK;
							total_q <= total_q + 1'b1;
							distinct_entries <= total_q + 1'b1;
						end
						state_q <= S_OUT;
					end else if (tup_rd_q == cur_q.tuple) begin
						state_q <= S_RDW;
					end else begin
						k_q <= k_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RDW: state_q <= S_WB;
				S_WB: begin
					entry_index <= addr_q;
					weight <= (wt_rd_q == '1) ? wt_rd_q : wt_rd_q + 32'd1;
					packed_tuple <= cur_q.tuple;
					status <= ST_OK;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/tuple_group_count_table.sv =====
// Top level: tuple group count table with decoupled front and back ends.
// A row end or read is queued as a command; the idle back end pops it, passes S_RD
// and S_CMP once per entry compared (max 256) or once for a read, then S_RDW and S_WB
// on a match, and raises out_valid in S_OUT; a faulted row goes straight to S_OUT.
// Throughput: one cell word per cycle while the two-word queue has room.
// Reset (arst_n low): table empty, tuple and fault cleared, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module tuple_group_count_table
	import tgct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [5:0]  column,
	input  wire logic [7:0]  cell_value,
	input  wire logic        row_end,
	input  wire logic [7:0]  read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       entry_index,
	output logic [31:0]      weight,
	output logic [63:0]      packed_tuple,
	output logic [8:0]       distinct_entries,
	output logic [1:0]       status
);
	logic [63:0] select_mask_q;
	logic [5:0]  node_column_q;
	logic [8:0]  outcome_limit_q;
	logic        cmd_valid, q_full, q_ne, q_pop;
	cmd_t        cmd, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_mask_q <= '0;
			node_column_q <= '0;
			outcome_limit_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SELECT: select_mask_q <= cfg_data;
				REG_NODE:   node_column_q <= cfg_data[5:0];
				REG_LIMIT:  outcome_limit_q <= cfg_data[8:0];
				default:    ;
			endcase
		end
	end

	tgct_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .column, .cell_value, .row_end,
		.read_index, .select_mask(select_mask_q), .node_column(node_column_q),
		.outcome_limit(outcome_limit_q), .cmd_valid, .cmd, .cmd_full(q_full)
	);

	tgct_queue u_queue (
		.clk, .arst_n, .push(cmd_valid && !q_full), .push_cmd(cmd), .full(q_full),
		.not_empty(q_ne), .head, .pop(q_pop)
	);

	tgct_back u_back (
		.clk, .arst_n, .cmd_valid(q_ne), .cmd(head), .cmd_pop(q_pop), .out_valid,
		.out_stall, .entry_index, .weight, .packed_tuple, .distinct_entries, .status
	);
endmodule
`default_nettype wire
